// ----- sv/i2cbe_pkg.sv -----
// Shared types and constants for the I2C master bit engine.
package i2cbe_pkg;

  localparam logic [9:0] HALF_PERIOD_RESET = 10'd5;
  localparam logic [7:0] POLL_LIMIT_RESET  = 8'd10;
  localparam int         QUEUE_DEPTH_DEF   = 4;

  // Register indexes on the configuration port (word address bit).
  localparam logic REG_HALF_PERIOD = 1'b0;
  localparam logic REG_POLL_LIMIT  = 1'b1;

  typedef enum logic [2:0] {
    CMD_IDLE  = 3'd0,
    CMD_START = 3'd1,
    CMD_STOP  = 3'd2,
    CMD_ACK   = 3'd3,
    CMD_NACK  = 3'd4,
    CMD_AWAIT = 3'd5,
    CMD_WRITE = 3'd6,
    CMD_READ  = 3'd7
  } cmd_t;

  typedef struct packed {
    logic [9:0] half_period_ticks;
    logic [7:0] ack_poll_limit;
  } cfg_t;

  typedef struct packed {
    cmd_t       cmd;
    logic [7:0] tx_byte;
    logic       sda_sample;
  } item_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_release;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_seen;
  } res_t;

endpackage

// ----- sv/i2cbe_if.sv -----
// Valid/ready channel interfaces for the command input and the result output.
interface i2cbe_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] action;
  logic [7:0] tx_byte;
  logic       sda_sample;

  modport source (output valid, output action, output tx_byte, output sda_sample,
                  input ready);
  modport sink (input valid, input action, input tx_byte, input sda_sample,
                output ready);
endinterface

interface i2cbe_out_if;
  logic       valid;
  logic       ready;
  logic       scl_level;
  logic       sda_release;
  logic       busy_res;
  logic       done_res;
  logic [7:0] rx_byte;
  logic       ack_seen;

  modport source (output valid, output scl_level, output sda_release,
                  output busy_res, output done_res, output rx_byte,
                  output ack_seen, input ready);
  modport sink (input valid, input scl_level, input sda_release, input busy_res,
                input done_res, input rx_byte, input ack_seen, output ready);
endinterface

// ----- sv/i2cbe_front.sv -----
// Front end: decodes the action field and pushes the item into the queue.
module i2cbe_front
  import i2cbe_pkg::*;
(
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [2:0] in_action,
  input  logic [7:0] in_tx_byte,
  input  logic       in_sda_sample,
  input  logic       q_full,
  output logic       q_push,
  output item_t      q_item
);

  cmd_t cmd;

  // Every action code maps onto a command; a tick is the idle code.
  assign cmd = cmd_t'(in_action);

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  // The byte only matters to a write; other items carry zero.
  assign q_item.cmd        = cmd;
  assign q_item.tx_byte    = (cmd == CMD_WRITE) ? in_tx_byte : 8'd0;
  assign q_item.sda_sample = in_sda_sample;

endmodule

// ----- sv/i2cbe_queue.sv -----
// Small FIFO between the front end and the bit engine.
module i2cbe_queue
  import i2cbe_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t push_item,
  input  logic  pop,
  output logic  full,
  output logic  not_empty,
  output item_t head
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  item_t          mem [DEPTH];
  logic [PW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]  cnt_r;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full      = (cnt_r == CW'(DEPTH));
  assign not_empty = (cnt_r != '0);
  assign head      = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH)) else $error("queue count over depth");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> not_empty) else $error("pop from empty queue");
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full) else $error("push into full queue");
`endif

endmodule

// ----- sv/i2cbe_back.sv -----
// Back end: the bit engine proper, stepped once per queued item, with an output register.
module i2cbe_back
  import i2cbe_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  cfg_t  cfg,
  input  logic  q_not_empty,
  input  item_t q_head,
  output logic  q_pop,
  output logic  out_valid,
  input  logic  out_ready,
  output res_t  out_res
);

  localparam logic [3:0] PH_0 = 4'd0;
  localparam logic [3:0] PH_1 = 4'd1;
  localparam logic [3:0] PH_2 = 4'd2;
  localparam logic [3:0] PH_3 = 4'd3;
  localparam logic [3:0] PH_4 = 4'd4;

  cmd_t       cmd_r, cmd_nxt;
  logic [3:0] phase_r, phase_nxt;
  logic [3:0] bit_r, bit_nxt;
  logic [7:0] shift_r, shift_nxt;
  logic [9:0] dly_r, dly_nxt;
  logic [7:0] poll_r, poll_nxt;
  logic       scl_r, scl_nxt;
  logic       sda_r, sda_nxt;
  logic       ack_r, ack_nxt;
  logic [7:0] rx_r, rx_nxt;
  logic       done;
  logic       step;
  logic       out_valid_r;
  res_t       out_res_r;
  logic [9:0] h;
  logic [7:0] lim;
  logic [9:0] dly_dec;
  logic [7:0] poll_base;

  assign h   = (cfg.half_period_ticks == '0) ? 10'd1 : cfg.half_period_ticks;
  assign lim = (cfg.ack_poll_limit == '0) ? 8'd1 : cfg.ack_poll_limit;

  assign step      = q_not_empty && (!out_valid_r || out_ready);
  assign q_pop     = step;
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;
  assign dly_dec   = dly_r - 10'd1;

  always_comb begin
    cmd_nxt   = cmd_r;
    phase_nxt = phase_r;
    bit_nxt   = bit_r;
    shift_nxt = shift_r;
    dly_nxt   = dly_r;
    poll_nxt  = poll_r;
    scl_nxt   = scl_r;
    sda_nxt   = sda_r;
    ack_nxt   = ack_r;
    rx_nxt    = rx_r;
    done      = 1'b0;
    poll_base = (phase_r == PH_1) ? lim : poll_r;

    if (cmd_r == CMD_IDLE) begin
      if (q_head.cmd != CMD_IDLE) begin
        cmd_nxt   = q_head.cmd;
        bit_nxt   = '0;
        phase_nxt = PH_0;
        dly_nxt   = h;
        case (q_head.cmd)
          CMD_START: begin scl_nxt = 1'b1; sda_nxt = 1'b1; end
          CMD_STOP:  begin scl_nxt = 1'b1; sda_nxt = 1'b0; end
          CMD_ACK:   begin scl_nxt = 1'b1; sda_nxt = 1'b0; end
          CMD_NACK:  begin scl_nxt = 1'b1; sda_nxt = 1'b1; end
          CMD_AWAIT: begin sda_nxt = 1'b1; end
          CMD_WRITE: begin
            shift_nxt = q_head.tx_byte;
            scl_nxt   = 1'b0;
            sda_nxt   = q_head.tx_byte[7];
            dly_nxt   = 10'd1;
          end
          default: begin
            shift_nxt = '0;
            scl_nxt   = 1'b0;
            sda_nxt   = 1'b1;
          end
        endcase
      end
    end else begin
      dly_nxt = dly_dec;
      if (dly_dec == '0) begin
        case (cmd_r)
          CMD_START: begin
            if (phase_r == PH_0) begin
              phase_nxt = PH_1; scl_nxt = 1'b1; sda_nxt = 1'b0; dly_nxt = h;
            end else begin
              scl_nxt = 1'b0; done = 1'b1;
            end
          end
          CMD_STOP: begin
            if (phase_r == PH_0) begin
              phase_nxt = PH_1; scl_nxt = 1'b1; sda_nxt = 1'b1; dly_nxt = h;
            end else begin
              done = 1'b1;
            end
          end
          CMD_ACK, CMD_NACK: begin
            scl_nxt = 1'b0; done = 1'b1;
          end
          CMD_AWAIT: begin
            if (phase_r == PH_0) begin
              phase_nxt = PH_1; scl_nxt = 1'b1; sda_nxt = 1'b1; dly_nxt = h;
            end else if (phase_r == PH_2 && poll_r == '0) begin
              phase_nxt = PH_3; scl_nxt = 1'b1; sda_nxt = 1'b0; dly_nxt = h;
            end else if (phase_r == PH_1 || phase_r == PH_2) begin
              // One acknowledge sample; a low level ends the command.
              if (!q_head.sda_sample) begin
                poll_nxt = poll_base;
                scl_nxt  = 1'b0;
                ack_nxt  = 1'b1;
                done     = 1'b1;
              end else begin
                poll_nxt  = poll_base - 8'd1;
                phase_nxt = PH_2;
                sda_nxt   = 1'b1;
                dly_nxt   = h;
              end
            end else if (phase_r == PH_3) begin
              phase_nxt = PH_4; scl_nxt = 1'b1; sda_nxt = 1'b1; dly_nxt = h;
            end else begin
              ack_nxt = 1'b0; done = 1'b1;
            end
          end
          CMD_WRITE: begin
            if (phase_r == PH_0) begin
              phase_nxt = PH_1; scl_nxt = 1'b1; dly_nxt = h;
            end else begin
              shift_nxt = {shift_r[6:0], 1'b0};
              bit_nxt   = bit_r + 4'd1;
              if (bit_nxt >= 4'd8) begin
                scl_nxt = 1'b0; done = 1'b1;
              end else begin
                phase_nxt = PH_0; scl_nxt = 1'b0; sda_nxt = shift_r[6]; dly_nxt = 10'd1;
              end
            end
          end
          CMD_READ: begin
            if (phase_r == PH_0) begin
              phase_nxt = PH_1; scl_nxt = 1'b1; sda_nxt = 1'b1; dly_nxt = h;
            end else begin
              shift_nxt = {shift_r[6:0], q_head.sda_sample};
              bit_nxt   = bit_r + 4'd1;
              if (bit_nxt >= 4'd8) begin
                scl_nxt = 1'b0;
                rx_nxt  = shift_nxt;
                done    = 1'b1;
              end else begin
                phase_nxt = PH_0; scl_nxt = 1'b0; sda_nxt = 1'b1; dly_nxt = h;
              end
            end
          end
          default: begin
            done = 1'b1;
          end
        endcase
        if (done) begin
          cmd_nxt   = CMD_IDLE;
          phase_nxt = PH_0;
          dly_nxt   = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_r       <= CMD_IDLE;
      phase_r     <= PH_0;
      bit_r       <= '0;
      shift_r     <= '0;
      dly_r       <= '0;
      poll_r      <= '0;
      scl_r       <= 1'b1;
      sda_r       <= 1'b1;
      ack_r       <= 1'b0;
      rx_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (step) begin
        cmd_r   <= cmd_nxt;
        phase_r <= phase_nxt;
        bit_r   <= bit_nxt;
        shift_r <= shift_nxt;
        dly_r   <= dly_nxt;
        poll_r  <= poll_nxt;
        scl_r   <= scl_nxt;
        sda_r   <= sda_nxt;
        ack_r   <= ack_nxt;
        rx_r    <= rx_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_res_r.scl_level   <= scl_nxt;
      out_res_r.sda_release <= sda_nxt;
      out_res_r.busy_res    <= (cmd_nxt != CMD_IDLE);
      out_res_r.done_res    <= done;
      out_res_r.rx_byte     <= rx_nxt;
      out_res_r.ack_seen    <= ack_nxt;
    end
  end

`ifndef SYNTHESIS
  a_busy_has_delay: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd_r != CMD_IDLE) |-> (dly_r != '0)) else $error("busy with zero delay");
  a_bit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    bit_r <= 4'd8) else $error("bit counter past eight");
  a_done_idles: assert property (@(posedge clk) disable iff (!rst_n)
    (step && done) |=> (cmd_r == CMD_IDLE)) else $error("engine busy after done");
  a_done_out: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.done_res) |-> !out_res_r.busy_res)
    else $error("done reported while busy");
`endif

endmodule

// ----- sv/i2c_master_bit_engine_top.sv -----
// Top level of the I2C master bit engine: channels, configuration registers, front, queue, back.
//
//   Channel   Direction  Handshake        Carries
//   in_chan   input      valid/ready      action, tx_byte, sda_sample
//   out_chan  output     valid/ready      scl_level, sda_release, busy_res, done_res,
//                                         rx_byte, ack_seen
//   cfg (APB) input      psel/penable     half_period_ticks at 0x0, ack_poll_limit at 0x4
//
// The engine takes one item per clock cycle unless a stalled output holds it;
// each transfer on the input yields exactly one transfer on the output. An
// accepted item is written into the queue; the engine steps it once it is at the
// head of the queue and the output register is free, and its result is held in
// the output register until it transfers. The rate is set by the single engine
// state update per cycle. Reset is synchronous and active low. While the output
// is stalled the queue keeps taking up to QUEUE_DEPTH items.
module i2c_master_bit_engine_top
  import i2cbe_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  i2cbe_in_if.sink           in_chan,
  i2cbe_out_if.source        out_chan,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic [9:0] half_r;
  logic [7:0] poll_lim_r;
  cfg_t       cfg;
  logic       cfg_wr;
  logic       q_full;
  logic       q_push;
  logic       q_pop;
  logic       q_not_empty;
  item_t      q_in;
  item_t      q_head;
  res_t       res;

  // Configuration registers. Writes are only expected while the engine is idle,
  // so the engine reads them directly without a shadow copy.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_r     <= HALF_PERIOD_RESET;
      poll_lim_r <= POLL_LIMIT_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_HALF_PERIOD) begin
        half_r <= pwdata[9:0];
      end else begin
        poll_lim_r <= pwdata[7:0];
      end
    end
  end

  always_comb begin
    case (paddr[2])
      REG_HALF_PERIOD: prdata = {22'd0, half_r};
      REG_POLL_LIMIT:  prdata = {24'd0, poll_lim_r};
      default:         prdata = '0;
    endcase
  end

  assign cfg.half_period_ticks = half_r;
  assign cfg.ack_poll_limit    = poll_lim_r;

  // The front decodes each transfer; the queue lets it keep accepting while the
  // back end waits on a stalled output.
  i2cbe_front u_front (
    .in_valid      (in_chan.valid),
    .in_ready      (in_chan.ready),
    .in_action     (in_chan.action),
    .in_tx_byte    (in_chan.tx_byte),
    .in_sda_sample (in_chan.sda_sample),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_item        (q_in)
  );

  i2cbe_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_in),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  // The back end holds the bus state and registers each result.
  i2cbe_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .out_valid   (out_chan.valid),
    .out_ready   (out_chan.ready),
    .out_res     (res)
  );

  assign out_chan.scl_level   = res.scl_level;
  assign out_chan.sda_release = res.sda_release;
  assign out_chan.busy_res    = res.busy_res;
  assign out_chan.done_res    = res.done_res;
  assign out_chan.rx_byte     = res.rx_byte;
  assign out_chan.ack_seen    = res.ack_seen;

endmodule

// ----- bench/testbench.sv -----
// Self-checking testbench for the I2C master bit engine top level.
`timescale 1ns / 1ps

module testbench;
  import i2cbe_pkg::*;

  // Clock, reset and the configuration port.
  logic        clk = 1'b0;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  i2cbe_in_if  in_chan ();
  i2cbe_out_if out_chan ();

  i2c_master_bit_engine_top DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Directed rows. A row is sent reps times; only rows whose outcome is obvious
  // carry a typed expectation, all others are checked against the bus predictor.
  typedef struct {
    cmd_t       cmd;
    logic [7:0] tx;
    logic       sda;
    int         reps;
    bit         typed;
    res_t       want;
  } drill_row_t;

  localparam res_t NO_CHECK = '0;
  localparam int   DRILL_ROWS = 21;

  // The directed rows run with a zero half period and a zero poll limit, so
  // every bus delay is one tick and await-ack takes a single sample.
  drill_row_t drill [DRILL_ROWS] = '{
    // A tick while idle changes nothing, whatever the unused fields hold.
    '{CMD_IDLE,  8'hFF, 1'b0, 1,  1'b1, '{1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0}},
    // Start is taken at once and shows its first segment, both lines high.
    '{CMD_START, 8'h00, 1'b1, 1,  1'b1, '{1'b1, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0}},
    // A read while busy is ignored; the start goes on to pull SDA low.
    '{CMD_READ,  8'h00, 1'b0, 1,  1'b0, NO_CHECK},
    // Start ends with SCL low, SDA still low and done pulsing.
    '{CMD_IDLE,  8'h00, 1'b1, 1,  1'b1, '{1'b0, 1'b0, 1'b0, 1'b1, 8'h00, 1'b0}},
    '{CMD_WRITE, 8'hA5, 1'b0, 1,  1'b0, NO_CHECK},
    '{CMD_IDLE,  8'h00, 1'b0, 16, 1'b0, NO_CHECK},
    '{CMD_READ,  8'h3C, 1'b1, 1,  1'b0, NO_CHECK},
    '{CMD_IDLE,  8'h00, 1'b1, 6,  1'b0, NO_CHECK},
    '{CMD_IDLE,  8'h00, 1'b0, 6,  1'b0, NO_CHECK},
    '{CMD_IDLE,  8'hFF, 1'b1, 4,  1'b0, NO_CHECK},
    // Await-ack with SDA held high: one sample, then stop and report NACK.
    '{CMD_AWAIT, 8'h00, 1'b1, 1,  1'b0, NO_CHECK},
    '{CMD_IDLE,  8'h00, 1'b1, 5,  1'b0, NO_CHECK},
    '{CMD_STOP,  8'h00, 1'b0, 1,  1'b0, NO_CHECK},
    '{CMD_IDLE,  8'h00, 1'b0, 2,  1'b0, NO_CHECK},
    '{CMD_ACK,   8'h00, 1'b0, 1,  1'b0, NO_CHECK},
    '{CMD_IDLE,  8'h00, 1'b0, 1,  1'b0, NO_CHECK},
    '{CMD_NACK,  8'h00, 1'b0, 1,  1'b0, NO_CHECK},
    '{CMD_IDLE,  8'h00, 1'b0, 1,  1'b0, NO_CHECK},
    // Await-ack that sees SDA low on its first sample.
    '{CMD_AWAIT, 8'h00, 1'b1, 1,  1'b0, NO_CHECK},
    '{CMD_IDLE,  8'h00, 1'b1, 1,  1'b0, NO_CHECK},
    '{CMD_IDLE,  8'h00, 1'b0, 1,  1'b0, NO_CHECK}
  };

  // Register settings walked by the random part, extremes included. The longest
  // half period makes every command long, so that setting runs one short command.
  typedef struct {
    logic [9:0] half;
    logic [7:0] limit;
    int         cmds;
  } timing_t;

  localparam int PLAN_LEN = 7;

  timing_t timing_plan [PLAN_LEN] = '{
    '{10'd1,    8'd1,   20},
    '{10'd2,    8'd4,   16},
    '{10'd0,    8'd255, 10},
    '{10'd3,    8'd0,   12},
    '{10'd1,    8'd10,  20},
    '{10'd1023, 8'd1,   1},
    '{10'd5,    8'd10,  6}
  };

  // Bus predictor state: a private copy of the engine and its registers.
  cfg_t       model_cfg;
  cmd_t       eng_cmd;
  logic [3:0] eng_phase;
  logic [3:0] eng_bits;
  logic [7:0] eng_shift;
  logic [9:0] eng_delay;
  logic [7:0] eng_polls;
  logic       eng_scl;
  logic       eng_sda;
  logic       eng_ack;
  logic [7:0] eng_rx;
  bit         step_done;

  // Results the engine owes us, oldest first.
  res_t expected_bus [$];

  int errors       = 0;
  int items_sent   = 0;
  int cmds_sent    = 0;
  int results_seen = 0;
  int settings_run = 0;

  // Sender burst state.
  int burst_left;
  bit valid_up;

  // Receiver stall pattern.
  logic [15:0] stall_mask;
  int          stall_age = 0;

  // A zero half period behaves as one tick.
  function automatic logic [9:0] bus_delay();
    return (model_cfg.half_period_ticks == '0) ? 10'd1 : model_cfg.half_period_ticks;
  endfunction

  task automatic load_segment(input logic [3:0] ph, input logic scl, input logic sda,
                              input logic [9:0] ticks);
    eng_phase = ph;
    eng_scl   = scl;
    eng_sda   = sda;
    eng_delay = ticks;
  endtask

  task automatic end_command();
    eng_cmd   = CMD_IDLE;
    eng_phase = '0;
    eng_delay = '0;
    step_done = 1'b1;
  endtask

  // One SDA sample of await-ack: a low level is the acknowledge.
  task automatic sample_ack(input logic sda_in);
    if (!sda_in) begin
      eng_scl = 1'b0;
      eng_ack = 1'b1;
      end_command();
    end else begin
      eng_polls = eng_polls - 8'd1;
      load_segment(4'd2, eng_scl, 1'b1, bus_delay());
    end
  endtask

  // The current segment has run out: move to the next one or finish.
  task automatic segment_expired(input logic sda_in);
    logic [9:0] h;
    h = bus_delay();
    case (eng_cmd)
      CMD_START: begin
        if (eng_phase == 4'd0) load_segment(4'd1, 1'b1, 1'b0, h);
        else begin
          eng_scl = 1'b0;
          end_command();
        end
      end
      CMD_STOP: begin
        if (eng_phase == 4'd0) load_segment(4'd1, 1'b1, 1'b1, h);
        else end_command();
      end
      CMD_ACK, CMD_NACK: begin
        eng_scl = 1'b0;
        end_command();
      end
      CMD_AWAIT: begin
        if (eng_phase == 4'd0) begin
          load_segment(4'd1, 1'b1, 1'b1, h);
        end else if (eng_phase == 4'd1) begin
          eng_polls = (model_cfg.ack_poll_limit == '0) ? 8'd1 : model_cfg.ack_poll_limit;
          sample_ack(sda_in);
        end else if (eng_phase == 4'd2) begin
          // Out of samples: run the stop sequence before reporting NACK.
          if (eng_polls == '0) load_segment(4'd3, 1'b1, 1'b0, h);
          else sample_ack(sda_in);
        end else if (eng_phase == 4'd3) begin
          load_segment(4'd4, 1'b1, 1'b1, h);
        end else begin
          eng_ack = 1'b0;
          end_command();
        end
      end
      CMD_WRITE: begin
        if (eng_phase == 4'd0) begin
          load_segment(4'd1, 1'b1, eng_sda, h);
        end else begin
          eng_shift = eng_shift << 1;
          eng_bits  = eng_bits + 4'd1;
          if (eng_bits >= 4'd8) begin
            eng_scl = 1'b0;
            end_command();
          end else begin
            load_segment(4'd0, 1'b0, eng_shift[7], 10'd1);
          end
        end
      end
      CMD_READ: begin
        if (eng_phase == 4'd0) begin
          load_segment(4'd1, 1'b1, 1'b1, h);
        end else begin
          eng_shift = {eng_shift[6:0], sda_in};
          eng_bits  = eng_bits + 4'd1;
          if (eng_bits >= 4'd8) begin
            eng_scl = 1'b0;
            eng_rx  = eng_shift;
            end_command();
          end else begin
            load_segment(4'd0, 1'b0, 1'b1, h);
          end
        end
      end
      default: end_command();
    endcase
  endtask

  // One engine step for an accepted input transfer; gives the bus levels and flags.
  task automatic advance_engine(input item_t it, output res_t bus);
    logic [9:0] h;
    h = bus_delay();
    step_done = 1'b0;
    if (eng_cmd == CMD_IDLE) begin
      if (it.cmd != CMD_IDLE) begin
        eng_cmd  = it.cmd;
        eng_bits = '0;
        case (it.cmd)
          CMD_START: load_segment(4'd0, 1'b1, 1'b1, h);
          CMD_STOP:  load_segment(4'd0, 1'b1, 1'b0, h);
          CMD_ACK:   load_segment(4'd0, 1'b1, 1'b0, h);
          CMD_NACK:  load_segment(4'd0, 1'b1, 1'b1, h);
          CMD_AWAIT: load_segment(4'd0, eng_scl, 1'b1, h);
          CMD_WRITE: begin
            // The first bit gets a single low tick, then SCL rises.
            eng_shift = it.tx_byte;
            load_segment(4'd0, 1'b0, it.tx_byte[7], 10'd1);
          end
          default: begin
            eng_shift = '0;
            load_segment(4'd0, 1'b0, 1'b1, h);
          end
        endcase
      end
    end else begin
      eng_delay = eng_delay - 10'd1;
      if (eng_delay == '0) segment_expired(it.sda_sample);
    end
    bus.scl_level   = eng_scl;
    bus.sda_release = eng_sda;
    bus.busy_res    = (eng_cmd != CMD_IDLE);
    bus.done_res    = step_done;
    bus.rx_byte     = eng_rx;
    bus.ack_seen    = eng_ack;
  endtask

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endfunction

  // Offer one item, wait for its transfer, then record what the engine owes.
  // The sender works in bursts; at the end of a burst it idles for a while.
  task automatic send_item(input item_t it, input bit typed, input res_t want);
    res_t bus;
    bit   was_idle;
    in_chan.valid      <= 1'b1;
    in_chan.action     <= it.cmd;
    in_chan.tx_byte    <= it.tx_byte;
    in_chan.sda_sample <= it.sda_sample;
    valid_up = 1'b1;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    was_idle = (eng_cmd == CMD_IDLE);
    advance_engine(it, bus);
    expected_bus.push_back(typed ? want : bus);
    // A tick to an idle engine does nothing; it is not counted.
    if (!(was_idle && it.cmd == CMD_IDLE)) items_sent++;
    if (was_idle && it.cmd != CMD_IDLE) cmds_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      in_chan.valid <= 1'b0;
      valid_up = 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(1, 24);
    end
  endtask

  // Run the engine back to idle with ticks, then hold off until every owed
  // result has come back and the pipeline has had time to empty.
  task automatic settle();
    item_t tick;
    while (eng_cmd != CMD_IDLE) begin
      tick.cmd        = CMD_IDLE;
      tick.tx_byte    = 8'($urandom);
      tick.sda_sample = 1'($urandom_range(0, 1));
      send_item(tick, 1'b0, NO_CHECK);
    end
    if (valid_up) begin
      in_chan.valid <= 1'b0;
      valid_up = 1'b0;
    end
    while (expected_bus.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic cfg_write(input logic idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic cfg_read(input logic idx, input logic [31:0] want);
    logic [31:0] got;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    got = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    if (got !== want) begin
      $error("register %0d: expected %0h, got %0h", idx, want, got);
      errors++;
    end
  endtask

  task automatic apply_timing(input logic [9:0] half, input logic [7:0] limit);
    cfg_write(REG_HALF_PERIOD, {22'd0, half});
    cfg_write(REG_POLL_LIMIT, {24'd0, limit});
    model_cfg.half_period_ticks = half;
    model_cfg.ack_poll_limit    = limit;
    cfg_read(REG_HALF_PERIOD, {22'd0, half});
    cfg_read(REG_POLL_LIMIT, {24'd0, limit});
    settings_run++;
  endtask

  // Result side: compare every transfer with the oldest owed result, and stall
  // on a random pattern drawn anew whenever the stall age wraps to zero; some patterns never stall.
  always @(posedge clk) begin
    res_t want;
    if (rst_n) begin
      if (out_chan.valid && out_chan.ready) begin
        results_seen++;
        if (expected_bus.size() == 0) begin
          $error("result transfer with nothing expected");
          errors++;
        end else begin
          want = expected_bus.pop_front();
          check_field("scl_level", 8'(want.scl_level), 8'(out_chan.scl_level));
          check_field("sda_release", 8'(want.sda_release), 8'(out_chan.sda_release));
          check_field("busy_res", 8'(want.busy_res), 8'(out_chan.busy_res));
          check_field("done_res", 8'(want.done_res), 8'(out_chan.done_res));
          check_field("rx_byte", want.rx_byte, out_chan.rx_byte);
          check_field("ack_seen", 8'(want.ack_seen), 8'(out_chan.ack_seen));
        end
      end
      if (stall_age == 0) begin
        case ($urandom_range(0, 3))
          0:       stall_mask = '1;
          1:       stall_mask = 16'($urandom);
          default: stall_mask = 16'($urandom | $urandom);
        endcase
        // Every pattern lets at least a few transfers through.
        stall_mask[0] = 1'b1;
      end
      out_chan.ready <= stall_mask[stall_age % 16];
      stall_age = (stall_age + 1) % 48;
    end else begin
      out_chan.ready <= 1'b0;
    end
  end

  // Stimulus: reset, register checks, the directed rows, then random traffic
  // under each register setting of the plan.
  initial begin
    item_t it;
    int    r;
    int    k;
    int    p;
    int    cmds_left;
    int    sda_mode;

    rst_n              <= 1'b0;
    in_chan.valid      <= 1'b0;
    in_chan.action     <= CMD_IDLE;
    in_chan.tx_byte    <= '0;
    in_chan.sda_sample <= 1'b1;
    psel               <= 1'b0;
    penable            <= 1'b0;
    pwrite             <= 1'b0;
    paddr              <= '0;
    pwdata             <= '0;

    model_cfg.half_period_ticks = HALF_PERIOD_RESET;
    model_cfg.ack_poll_limit    = POLL_LIMIT_RESET;
    eng_cmd   = CMD_IDLE;
    eng_phase = '0;
    eng_bits  = '0;
    eng_shift = '0;
    eng_delay = '0;
    eng_polls = '0;
    eng_scl   = 1'b1;
    eng_sda   = 1'b1;
    eng_ack   = 1'b0;
    eng_rx    = '0;
    valid_up  = 1'b0;
    sda_mode  = 0;
    burst_left = $urandom_range(1, 24);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Both registers must come out of reset at their documented values.
    cfg_read(REG_HALF_PERIOD, {22'd0, HALF_PERIOD_RESET});
    cfg_read(REG_POLL_LIMIT, {24'd0, POLL_LIMIT_RESET});

    // Zero in either register acts as one.
    apply_timing(10'd0, 8'd0);
    for (r = 0; r < DRILL_ROWS; r++) begin
      it.cmd        = drill[r].cmd;
      it.tx_byte    = drill[r].tx;
      it.sda_sample = drill[r].sda;
      for (k = 0; k < drill[r].reps; k++) send_item(it, drill[r].typed, drill[r].want);
    end
    settle();

    for (p = 0; p < PLAN_LEN; p++) begin
      apply_timing(timing_plan[p].half, timing_plan[p].limit);
      cmds_left = timing_plan[p].cmds;
      while (cmds_left > 0) begin
        if (eng_cmd == CMD_IDLE) begin
          // Mostly a fresh command; now and then an idle tick.
          if ($urandom_range(0, 9) == 0) begin
            it.cmd = CMD_IDLE;
          end else begin
            it.cmd = cmd_t'($urandom_range(1, 7));
            // Under a very long half period only a one-segment command runs.
            if (timing_plan[p].half > 10'd255) begin
              it.cmd = ($urandom_range(0, 1) != 0) ? CMD_ACK : CMD_NACK;
            end
            cmds_left--;
            sda_mode = $urandom_range(0, 3);
          end
        end else begin
          // Mostly ticks; a stray command now and then must be ignored.
          it.cmd = ($urandom_range(0, 11) == 0) ? cmd_t'($urandom_range(1, 7)) : CMD_IDLE;
        end
        it.tx_byte = 8'($urandom);
        // The SDA pattern is picked per command: noise, mostly high, stuck high
        // (forces the NACK path and reads of all ones) or stuck low.
        case (sda_mode)
          0:       it.sda_sample = 1'($urandom_range(0, 1));
          1:       it.sda_sample = ($urandom_range(0, 15) != 0);
          2:       it.sda_sample = 1'b1;
          default: it.sda_sample = 1'b0;
        endcase
        send_item(it, 1'b0, NO_CHECK);
      end
      settle();
    end

    $display("Covered %0d input transfers carrying %0d bus commands under %0d timing settings.",
             items_sent, cmds_sent, settings_run);
    $display("Compared %0d result transfers; %0d mismatches.", results_seen, errors);
    if (errors == 0 && expected_bus.size() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #10_000_000;
    $display("testbench: done, errors");
    $finish;
  end

endmodule
